// ===== sv/lv_pkg.sv =====
// Shared types, codes and arithmetic helpers for the Lotka-Volterra step engine.
// No dependencies; every other file of the block imports this package.
package lv_pkg;

    localparam int DATA_W  = 32;
    localparam int Q_FRAC  = 24;
    localparam int ACC_W   = 48;
    localparam int SUM_W   = 40;
    localparam int DVD_W   = 56;
    localparam int QM_W    = 57;
    localparam int PROD_W  = 64;

    localparam int MAX_SPECIES_DEF = 16;
    localparam int MAX_STIMULI_DEF = 8;
    localparam int MAX_RESULTS     = 16;

    localparam logic [1:0] REQ_ABUND = 2'd0;
    localparam logic [1:0] REQ_STIM  = 2'd1;
    localparam logic [1:0] REQ_COEF  = 2'd2;
    localparam logic [1:0] REQ_STEP  = 2'd3;

    localparam logic [2:0] TAB_BIRTH  = 3'd0;
    localparam logic [2:0] TAB_DEATH  = 3'd1;
    localparam logic [2:0] TAB_SBIRTH = 3'd2;
    localparam logic [2:0] TAB_SDEATH = 3'd3;
    localparam logic [2:0] TAB_XBIRTH = 3'd4;
    localparam logic [2:0] TAB_XDEATH = 3'd5;

    localparam logic [1:0] CFG_SPECIES = 2'd0;
    localparam logic [1:0] CFG_STIMULI = 2'd1;
    localparam logic [1:0] CFG_NORM    = 2'd2;

    localparam logic [4:0] SPECIES_RST = 5'd1;
    localparam logic [3:0] STIMULI_RST = 4'd0;
    localparam logic       NORM_RST    = 1'b1;

    localparam logic [ACC_W-1:0] ONE_Q = 48'h0000_0100_0000;

    typedef struct packed {
        logic              sat;
        logic [DATA_W-1:0] val;
    } lv_res_t;

    typedef struct packed {
        logic       clr_en;
        logic       load_en;
        logic       init;
        logic       term_sp;
        logic       term_st;
        logic       fin_lo;
        logic       fin_hi;
        logic       fin_st;
        logic       sum_clr;
        logic       nrd;
        logic       ndiv_go;
        logic       nwr;
        logic       erd;
        logic       commit;
        logic [3:0] idx_i;
        logic [3:0] idx_j;
    } lv_cmd_t;

    typedef struct packed {
        logic sum_nz;
        logic div_done;
    } lv_stat_t;

    // Depth of the largest table, which sets the length of the clearing sweep.
    function automatic int lv_clr_depth(input int sp, input int st);
        int a;
        int b;
        a = sp * sp;
        b = st * sp;
        return (a > b) ? a : b;
    endfunction

    function automatic logic [DATA_W-1:0] lv_mag32(input logic [DATA_W-1:0] v);
        return v[DATA_W-1] ? (~v + 32'd1) : v;
    endfunction

    // Applies a sign to a magnitude and clips it to the signed 32-bit range.
    function automatic lv_res_t lv_sat(input logic neg, input logic [QM_W-1:0] mag);
        lv_res_t r;
        if (!neg) begin
            r.sat = (mag > QM_W'(32'h7fff_ffff));
            r.val = r.sat ? 32'h7fff_ffff : mag[DATA_W-1:0];
        end
        else begin
            r.sat = (mag > QM_W'(32'h8000_0000));
            r.val = r.sat ? 32'h8000_0000 : (~mag[DATA_W-1:0] + 32'd1);
        end
        return r;
    endfunction

endpackage

// ===== sv/lv_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on lv_pkg for the operand widths.
module lv_div import lv_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DVD_W-1:0]  dividend,
    input  logic [SUM_W-1:0]  divisor,
    output logic              done,
    output logic [DVD_W-1:0]  quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [SUM_W-1:0] rem_reg;
    logic [SUM_W-1:0] rem_next;
    logic [DVD_W-1:0] quo_reg;
    logic [DVD_W-1:0] quo_next;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [SUM_W:0]   shifted;
    logic [SUM_W+1:0] diff;
    logic             ge;

    always_comb
    begin
        shifted  = {rem_reg, quo_reg[DVD_W-1]};
        diff     = {1'b0, shifted} - {2'b00, divisor};
        ge       = !diff[SUM_W+1];
        rem_next = ge ? diff[SUM_W-1:0] : shifted[SUM_W-1:0];
        quo_next = {quo_reg[DVD_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DVD_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== sv/lv_datapath.sv =====
// Datapath: coefficient and abundance stores, the multiply-accumulate pipeline,
// the final growth product, the running total and the normalising divider.
// Depends on lv_pkg and lv_div.
module lv_datapath import lv_pkg::*;
#(
    parameter int MAX_SPECIES = MAX_SPECIES_DEF,
    parameter int MAX_STIMULI = MAX_STIMULI_DEF,
    parameter int CLR_W       = 9
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  lv_cmd_t           cmd,
    input  logic [CLR_W-1:0]  clr_idx,
    input  logic [1:0]        req_type,
    input  logic [2:0]        table_select,
    input  logic [3:0]        source_index,
    input  logic [3:0]        target_index,
    input  logic [31:0]       load_value,
    output lv_stat_t          stat,
    output logic [31:0]       abundance,
    output logic              saturated
);

    localparam int SP_AW = (MAX_SPECIES > 1) ? $clog2(MAX_SPECIES) : 1;
    localparam int ST_AW = (MAX_STIMULI > 1) ? $clog2(MAX_STIMULI) : 1;
    localparam int SM_D  = MAX_SPECIES * MAX_SPECIES;
    localparam int XM_D  = MAX_STIMULI * MAX_SPECIES;
    localparam int SM_AW = (SM_D > 1) ? $clog2(SM_D) : 1;
    localparam int XM_AW = (XM_D > 1) ? $clog2(XM_D) : 1;

    logic [DATA_W-1:0] abund_mem [MAX_SPECIES];
    logic [DATA_W-1:0] stim_mem  [MAX_STIMULI];
    logic [DATA_W-1:0] birth_mem [MAX_SPECIES];
    logic [DATA_W-1:0] death_mem [MAX_SPECIES];
    logic [DATA_W-1:0] sb_mem    [SM_D];
    logic [DATA_W-1:0] sd_mem    [SM_D];
    logic [DATA_W-1:0] xb_mem    [XM_D];
    logic [DATA_W-1:0] xd_mem    [XM_D];
    lv_res_t           next_mem  [MAX_SPECIES];

    logic [DATA_W-1:0] abund_rd_reg;
    logic [DATA_W-1:0] stim_rd_reg;
    logic [DATA_W-1:0] birth_rd_reg;
    logic [DATA_W-1:0] death_rd_reg;
    logic [DATA_W-1:0] sb_rd_reg;
    logic [DATA_W-1:0] sd_rd_reg;
    logic [DATA_W-1:0] xb_rd_reg;
    logic [DATA_W-1:0] xd_rd_reg;
    lv_res_t           next_rd_reg;

    logic op1_init_reg;
    logic op1_sp_reg;
    logic op1_st_reg;
    logic op2_init_reg;
    logic op2_term_reg;

    logic [PROD_W-1:0] prod_b_reg;
    logic [PROD_W-1:0] prod_d_reg;
    logic              neg_b_reg;
    logic              neg_d_reg;
    logic [ACC_W-1:0]  base_reg;
    logic [DATA_W-1:0] xi_reg;
    logic [ACC_W-1:0]  f_reg;
    logic [ACC_W-1:0]  f_next;
    logic [DATA_W-1:0] lo_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [SUM_W-1:0]  sum_next;

    logic              ld_ab, ld_st, ld_br, ld_dr, ld_sb, ld_sd, ld_xb, ld_xd;
    logic              src_sp_ok, src_st_ok, dst_sp_ok;
    logic [SP_AW-1:0]  ld_sp_addr, clr_sp, i_sp, j_sp, rd_sp;
    logic [ST_AW-1:0]  ld_st_addr, clr_st, j_st;
    logic [SM_AW-1:0]  ld_sm_addr, clr_sm, rd_sm;
    logic [XM_AW-1:0]  ld_xm_addr, clr_xm, rd_xm;
    logic              clr_sp_ok, clr_st_ok, clr_sm_ok, clr_xm_ok;

    logic [DATA_W-1:0] coef_b, coef_d, src_v;
    logic [DATA_W-1:0] mb_a, mb_b;
    logic [ACC_W-1:0]  tb_ext, td_ext, tb_s, td_s;
    logic [ACC_W-1:0]  fmag;
    logic [QM_W-1:0]   fin_qmag;
    lv_res_t           fin_res;
    lv_res_t           norm_raw;
    lv_res_t           norm_res;
    logic [DATA_W-1:0] nvmag;
    logic [SUM_W-1:0]  sum_mag;
    logic              div_done;
    logic [DVD_W-1:0]  quotient;

    // Load decoding; indices beyond a table are dropped.
    always_comb
    begin
        src_sp_ok = int'(source_index) < MAX_SPECIES;
        src_st_ok = int'(source_index) < MAX_STIMULI;
        dst_sp_ok = int'(target_index) < MAX_SPECIES;
        ld_ab = cmd.load_en && (req_type == REQ_ABUND) && src_sp_ok;
        ld_st = cmd.load_en && (req_type == REQ_STIM) && src_st_ok;
        ld_br = cmd.load_en && (req_type == REQ_COEF) && (table_select == TAB_BIRTH)
                && src_sp_ok;
        ld_dr = cmd.load_en && (req_type == REQ_COEF) && (table_select == TAB_DEATH)
                && src_sp_ok;
        ld_sb = cmd.load_en && (req_type == REQ_COEF) && (table_select == TAB_SBIRTH)
                && src_sp_ok && dst_sp_ok;
        ld_sd = cmd.load_en && (req_type == REQ_COEF) && (table_select == TAB_SDEATH)
                && src_sp_ok && dst_sp_ok;
        ld_xb = cmd.load_en && (req_type == REQ_COEF) && (table_select == TAB_XBIRTH)
                && src_st_ok && dst_sp_ok;
        ld_xd = cmd.load_en && (req_type == REQ_COEF) && (table_select == TAB_XDEATH)
                && src_st_ok && dst_sp_ok;

        ld_sp_addr = SP_AW'(source_index);
        ld_st_addr = ST_AW'(source_index);
        ld_sm_addr = SM_AW'(int'(source_index) * MAX_SPECIES + int'(target_index));
        ld_xm_addr = XM_AW'(int'(source_index) * MAX_SPECIES + int'(target_index));

        clr_sp    = SP_AW'(clr_idx);
        clr_st    = ST_AW'(clr_idx);
        clr_sm    = SM_AW'(clr_idx);
        clr_xm    = XM_AW'(clr_idx);
        clr_sp_ok = cmd.clr_en && (int'(clr_idx) < MAX_SPECIES);
        clr_st_ok = cmd.clr_en && (int'(clr_idx) < MAX_STIMULI);
        clr_sm_ok = cmd.clr_en && (int'(clr_idx) < SM_D);
        clr_xm_ok = cmd.clr_en && (int'(clr_idx) < XM_D);

        i_sp  = SP_AW'(cmd.idx_i);
        j_sp  = SP_AW'(cmd.idx_j);
        j_st  = ST_AW'(cmd.idx_j);
        rd_sp = cmd.init ? i_sp : j_sp;
        // Column of the influenced species, row of the influencing one.
        rd_sm = SM_AW'(int'(cmd.idx_j) * MAX_SPECIES + int'(cmd.idx_i));
        rd_xm = XM_AW'(int'(cmd.idx_j) * MAX_SPECIES + int'(cmd.idx_i));
    end

    always_ff @(posedge clk)
    begin
        if (clr_sp_ok)
            abund_mem[clr_sp] <= '0;
        else if (ld_ab)
            abund_mem[ld_sp_addr] <= load_value;
        else if (cmd.commit)
            abund_mem[i_sp] <= next_rd_reg.val;
        abund_rd_reg <= abund_mem[rd_sp];
    end

    always_ff @(posedge clk)
    begin
        if (clr_st_ok)
            stim_mem[clr_st] <= '0;
        else if (ld_st)
            stim_mem[ld_st_addr] <= load_value;
        stim_rd_reg <= stim_mem[j_st];
    end

    always_ff @(posedge clk)
    begin
        if (clr_sp_ok)
            birth_mem[clr_sp] <= '0;
        else if (ld_br)
            birth_mem[ld_sp_addr] <= load_value;
        birth_rd_reg <= birth_mem[i_sp];
    end

    always_ff @(posedge clk)
    begin
        if (clr_sp_ok)
            death_mem[clr_sp] <= '0;
        else if (ld_dr)
            death_mem[ld_sp_addr] <= load_value;
        death_rd_reg <= death_mem[i_sp];
    end

    always_ff @(posedge clk)
    begin
        if (clr_sm_ok)
            sb_mem[clr_sm] <= '0;
        else if (ld_sb)
            sb_mem[ld_sm_addr] <= load_value;
        sb_rd_reg <= sb_mem[rd_sm];
    end

    always_ff @(posedge clk)
    begin
        if (clr_sm_ok)
            sd_mem[clr_sm] <= '0;
        else if (ld_sd)
            sd_mem[ld_sm_addr] <= load_value;
        sd_rd_reg <= sd_mem[rd_sm];
    end

    always_ff @(posedge clk)
    begin
        if (clr_xm_ok)
            xb_mem[clr_xm] <= '0;
        else if (ld_xb)
            xb_mem[ld_xm_addr] <= load_value;
        xb_rd_reg <= xb_mem[rd_xm];
    end

    always_ff @(posedge clk)
    begin
        if (clr_xm_ok)
            xd_mem[clr_xm] <= '0;
        else if (ld_xd)
            xd_mem[ld_xm_addr] <= load_value;
        xd_rd_reg <= xd_mem[rd_xm];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fin_st)
            next_mem[i_sp] <= fin_res;
        else if (cmd.nwr)
            next_mem[i_sp] <= norm_res;
        if (cmd.nrd || cmd.erd)
            next_rd_reg <= next_mem[i_sp];
    end

    // Pipeline occupancy: read, multiply, accumulate.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op1_init_reg <= 1'b0;
            op1_sp_reg   <= 1'b0;
            op1_st_reg   <= 1'b0;
            op2_init_reg <= 1'b0;
            op2_term_reg <= 1'b0;
            f_reg        <= '0;
            sum_reg      <= '0;
        end
        else
        begin
            op1_init_reg <= cmd.init;
            op1_sp_reg   <= cmd.term_sp;
            op1_st_reg   <= cmd.term_st;
            op2_init_reg <= op1_init_reg;
            op2_term_reg <= op1_sp_reg || op1_st_reg;
            f_reg        <= f_next;
            sum_reg      <= sum_next;
        end
    end

    always_comb
    begin
        coef_b = op1_st_reg ? xb_rd_reg : sb_rd_reg;
        coef_d = op1_st_reg ? xd_rd_reg : sd_rd_reg;
        src_v  = op1_st_reg ? stim_rd_reg : abund_rd_reg;
        fmag   = f_reg[ACC_W-1] ? (~f_reg + ACC_W'(1)) : f_reg;

        // The birth multiplier also forms the two halves of abundance times factor.
        if (cmd.fin_lo)
        begin
            mb_a = lv_mag32(xi_reg);
            mb_b = {8'b0, fmag[23:0]};
        end
        else if (cmd.fin_hi)
        begin
            mb_a = lv_mag32(xi_reg);
            mb_b = {9'b0, fmag[46:24]};
        end
        else
        begin
            mb_a = lv_mag32(coef_b);
            mb_b = lv_mag32(src_v);
        end

        tb_ext = {8'b0, prod_b_reg[PROD_W-1:Q_FRAC]};
        td_ext = {8'b0, prod_d_reg[PROD_W-1:Q_FRAC]};
        tb_s   = neg_b_reg ? (~tb_ext + ACC_W'(1)) : tb_ext;
        td_s   = neg_d_reg ? (~td_ext + ACC_W'(1)) : td_ext;

        if (op2_init_reg)
            f_next = base_reg;
        else if (op2_term_reg)
            f_next = f_reg + tb_s - td_s;
        else
            f_next = f_reg;

        fin_qmag = QM_W'(prod_b_reg[55:0]) + QM_W'(lo_reg);
        fin_res  = lv_sat(xi_reg[DATA_W-1] ^ f_reg[ACC_W-1], fin_qmag);

        if (cmd.sum_clr)
            sum_next = '0;
        else if (cmd.fin_st)
            sum_next = sum_reg + {{(SUM_W-DATA_W){fin_res.val[DATA_W-1]}}, fin_res.val};
        else
            sum_next = sum_reg;

        nvmag    = lv_mag32(next_rd_reg.val);
        sum_mag  = sum_reg[SUM_W-1] ? (~sum_reg + SUM_W'(1)) : sum_reg;
        norm_raw = lv_sat(next_rd_reg.val[DATA_W-1] ^ sum_reg[SUM_W-1], {1'b0, quotient});
        norm_res.sat = norm_raw.sat | next_rd_reg.sat;
        norm_res.val = norm_raw.val;
    end

    always_ff @(posedge clk)
    begin
        prod_b_reg <= PROD_W'(mb_a) * PROD_W'(mb_b);
        prod_d_reg <= PROD_W'(lv_mag32(coef_d)) * PROD_W'(lv_mag32(src_v));
        neg_b_reg  <= coef_b[DATA_W-1] ^ src_v[DATA_W-1];
        neg_d_reg  <= coef_d[DATA_W-1] ^ src_v[DATA_W-1];
        base_reg   <= ONE_Q + {{(ACC_W-DATA_W){birth_rd_reg[DATA_W-1]}}, birth_rd_reg}
                            - {{(ACC_W-DATA_W){death_rd_reg[DATA_W-1]}}, death_rd_reg};
        if (op1_init_reg)
            xi_reg <= abund_rd_reg;
        if (cmd.fin_hi)
            lo_reg <= prod_b_reg[55:24];
    end

    lv_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.ndiv_go),
        .dividend ({nvmag, 24'b0}),
        .divisor  (sum_mag),
        .done     (div_done),
        .quotient (quotient)
    );

    assign stat.sum_nz   = (sum_reg != '0);
    assign stat.div_done = div_done;
    assign abundance     = next_rd_reg.val;
    assign saturated     = next_rd_reg.sat;

endmodule

// ===== sv/lv_ctrl.sv =====
// Controller: clearing sweep, load acceptance and the sequencing of one step.
// Depends on lv_pkg; drives lv_datapath through lv_cmd_t.
module lv_ctrl import lv_pkg::*;
#(
    parameter int MAX_SPECIES = MAX_SPECIES_DEF,
    parameter int MAX_STIMULI = MAX_STIMULI_DEF,
    parameter int CLR_W       = 9
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [1:0]       req_type,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [3:0]       species_index,
    output logic             last,
    input  logic [4:0]       cfg_species,
    input  logic [3:0]       cfg_stimuli,
    input  logic             cfg_norm,
    input  lv_stat_t         stat,
    output lv_cmd_t          cmd,
    output logic [CLR_W-1:0] clr_idx
);

    localparam int CLR_DEPTH = lv_clr_depth(MAX_SPECIES, MAX_STIMULI);
    localparam int NCAP = (MAX_SPECIES < MAX_RESULTS) ? MAX_SPECIES : MAX_RESULTS;

    typedef enum logic [16:0] {
        ST_CLEAR   = 17'b0_0000_0000_0000_0001,
        ST_IDLE    = 17'b0_0000_0000_0000_0010,
        ST_INIT    = 17'b0_0000_0000_0000_0100,
        ST_TERM_SP = 17'b0_0000_0000_0000_1000,
        ST_TERM_ST = 17'b0_0000_0000_0001_0000,
        ST_DRAIN1  = 17'b0_0000_0000_0010_0000,
        ST_DRAIN2  = 17'b0_0000_0000_0100_0000,
        ST_FIN_LO  = 17'b0_0000_0000_1000_0000,
        ST_FIN_HI  = 17'b0_0000_0001_0000_0000,
        ST_FIN_ST  = 17'b0_0000_0010_0000_0000,
        ST_DECIDE  = 17'b0_0000_0100_0000_0000,
        ST_NORM_RD = 17'b0_0000_1000_0000_0000,
        ST_NORM_GO = 17'b0_0001_0000_0000_0000,
        ST_NORM_WT = 17'b0_0010_0000_0000_0000,
        ST_NORM_WR = 17'b0_0100_0000_0000_0000,
        ST_EMIT_RD = 17'b0_1000_0000_0000_0000,
        ST_EMIT    = 17'b1_0000_0000_0000_0000
    } lv_state_t;

    lv_state_t        state_reg, state_next;
    logic [3:0]       i_reg, i_next;
    logic [3:0]       j_reg, j_next;
    logic [4:0]       n_reg, n_next;
    logic [3:0]       m_reg, m_next;
    logic [CLR_W-1:0] clr_reg, clr_next;
    logic [4:0]       n_eff;
    logic [3:0]       m_eff;
    logic             step_go;
    logic             i_last;

    always_comb
    begin
        n_eff   = (int'(cfg_species) > NCAP) ? 5'(NCAP) : cfg_species;
        m_eff   = (int'(cfg_stimuli) > MAX_STIMULI) ? 4'(MAX_STIMULI) : cfg_stimuli;
        in_ready  = (state_reg == ST_IDLE);
        out_valid = (state_reg == ST_EMIT);
        step_go = in_valid && in_ready && (req_type == REQ_STEP);
        i_last  = ({1'b0, i_reg} == (n_reg - 5'd1));

        cmd         = '0;
        cmd.idx_i   = i_reg;
        cmd.idx_j   = j_reg;
        cmd.clr_en  = (state_reg == ST_CLEAR);
        cmd.load_en = in_valid && in_ready && (req_type != REQ_STEP);
        cmd.sum_clr = step_go;
        cmd.init    = (state_reg == ST_INIT);
        cmd.term_sp = (state_reg == ST_TERM_SP);
        cmd.term_st = (state_reg == ST_TERM_ST);
        cmd.fin_lo  = (state_reg == ST_FIN_LO);
        cmd.fin_hi  = (state_reg == ST_FIN_HI);
        cmd.fin_st  = (state_reg == ST_FIN_ST);
        cmd.nrd     = (state_reg == ST_NORM_RD);
        cmd.ndiv_go = (state_reg == ST_NORM_GO);
        cmd.nwr     = (state_reg == ST_NORM_WR);
        cmd.erd     = (state_reg == ST_EMIT_RD);
        cmd.commit  = out_valid && out_ready;

        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        n_next     = n_reg;
        m_next     = m_reg;
        clr_next   = clr_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == CLR_W'(CLR_DEPTH - 1))
                    state_next = ST_IDLE;
                else
                    clr_next = clr_reg + CLR_W'(1);
            end
            ST_IDLE:
            begin
                // A step with no species in use finishes at once.
                if (step_go && (n_eff != 5'd0))
                begin
                    n_next     = n_eff;
                    m_next     = m_eff;
                    i_next     = '0;
                    state_next = ST_INIT;
                end
            end
            ST_INIT:
            begin
                j_next     = '0;
                state_next = ST_TERM_SP;
            end
            ST_TERM_SP:
            begin
                if ({1'b0, j_reg} == (n_reg - 5'd1))
                begin
                    j_next     = '0;
                    state_next = (m_reg != 4'd0) ? ST_TERM_ST : ST_DRAIN1;
                end
                else
                    j_next = j_reg + 4'd1;
            end
            ST_TERM_ST:
            begin
                if (j_reg == (m_reg - 4'd1))
                    state_next = ST_DRAIN1;
                else
                    j_next = j_reg + 4'd1;
            end
            ST_DRAIN1: state_next = ST_DRAIN2;
            ST_DRAIN2: state_next = ST_FIN_LO;
            ST_FIN_LO: state_next = ST_FIN_HI;
            ST_FIN_HI: state_next = ST_FIN_ST;
            ST_FIN_ST:
            begin
                if (i_last)
                begin
                    i_next     = '0;
                    state_next = ST_DECIDE;
                end
                else
                begin
                    i_next     = i_reg + 4'd1;
                    state_next = ST_INIT;
                end
            end
            ST_DECIDE:
            begin
                state_next = (cfg_norm && stat.sum_nz) ? ST_NORM_RD : ST_EMIT_RD;
            end
            ST_NORM_RD: state_next = ST_NORM_GO;
            ST_NORM_GO: state_next = ST_NORM_WT;
            ST_NORM_WT:
            begin
                if (stat.div_done)
                    state_next = ST_NORM_WR;
            end
            ST_NORM_WR:
            begin
                if (i_last)
                begin
                    i_next     = '0;
                    state_next = ST_EMIT_RD;
                end
                else
                begin
                    i_next     = i_reg + 4'd1;
                    state_next = ST_NORM_RD;
                end
            end
            ST_EMIT_RD: state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (out_ready)
                begin
                    if (i_last)
                        state_next = ST_IDLE;
                    else
                    begin
                        i_next     = i_reg + 4'd1;
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            i_reg     <= '0;
            j_reg     <= '0;
            n_reg     <= '0;
            m_reg     <= '0;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            n_reg     <= n_next;
            m_reg     <= m_next;
            clr_reg   <= clr_next;
        end
    end

    assign species_index = i_reg;
    assign last          = out_valid && i_last;
    assign clr_idx       = clr_reg;

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input accepted while a result beat is pending");

    a_step_start: assert property (@(posedge clk) disable iff (!rst_n)
        (step_go && (n_eff != 5'd0)) |=> (state_reg == ST_INIT))
        else $error("step did not start its first species");

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && last) |=> in_ready)
        else $error("block not idle after the final result beat");

    a_div_wr: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_NORM_WT) && stat.div_done) |=> (state_reg == ST_NORM_WR))
        else $error("divider result not written back");

endmodule

// ===== sv/lotka_volterra_step.sv =====
// Lotka-Volterra Euler step engine: top level with the register port.
// A step forms the new values through the single multiply-accumulate pipeline,
// divides each of them when normalising (one quotient bit per cycle), then emits
// the result beats. Reset starts a clearing sweep over the largest table, of
// MAX_SPECIES*max(MAX_SPECIES,MAX_STIMULI) entries (256 with the defaults), during
// which no item is taken; registers return to defaults.
module lotka_volterra_step import lv_pkg::*;
#(
    parameter int MAX_SPECIES = MAX_SPECIES_DEF,
    parameter int MAX_STIMULI = MAX_STIMULI_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  req_type,
    input  logic [2:0]  table_select,
    input  logic [3:0]  source_index,
    input  logic [3:0]  target_index,
    input  logic [31:0] load_value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  species_index,
    output logic [31:0] abundance,
    output logic        last,
    output logic        saturated
);

    localparam int CLR_W = $clog2(lv_clr_depth(MAX_SPECIES, MAX_STIMULI) + 1);

    logic [4:0]       species_count_reg;
    logic [3:0]       stimulus_count_reg;
    logic             normalize_enable_reg;
    logic             cfg_wr;
    lv_cmd_t          cmd;
    lv_stat_t         stat;
    logic [CLR_W-1:0] clr_idx;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            species_count_reg    <= SPECIES_RST;
            stimulus_count_reg   <= STIMULI_RST;
            normalize_enable_reg <= NORM_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                CFG_SPECIES: species_count_reg    <= pwdata[4:0];
                CFG_STIMULI: stimulus_count_reg   <= pwdata[3:0];
                CFG_NORM:    normalize_enable_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            CFG_SPECIES: prdata = {27'b0, species_count_reg};
            CFG_STIMULI: prdata = {28'b0, stimulus_count_reg};
            CFG_NORM:    prdata = {31'b0, normalize_enable_reg};
            default:     prdata = '0;
        endcase
    end

    lv_ctrl #(
        .MAX_SPECIES (MAX_SPECIES),
        .MAX_STIMULI (MAX_STIMULI),
        .CLR_W       (CLR_W)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .req_type      (req_type),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .species_index (species_index),
        .last          (last),
        .cfg_species   (species_count_reg),
        .cfg_stimuli   (stimulus_count_reg),
        .cfg_norm      (normalize_enable_reg),
        .stat          (stat),
        .cmd           (cmd),
        .clr_idx       (clr_idx)
    );

    lv_datapath #(
        .MAX_SPECIES (MAX_SPECIES),
        .MAX_STIMULI (MAX_STIMULI),
        .CLR_W       (CLR_W)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .clr_idx      (clr_idx),
        .req_type     (req_type),
        .table_select (table_select),
        .source_index (source_index),
        .target_index (target_index),
        .load_value   (load_value),
        .stat         (stat),
        .abundance    (abundance),
        .saturated    (saturated)
    );

endmodule
